### src/salct_pkg.sv
// Shared constants and types for the set-associative LRU tag block.
package salct_pkg;
	localparam int DefWays      = 4;
	localparam int DefLines     = 512;
	localparam int DefLineBytes = 32;
	localparam int AddrW        = 32;
	localparam int CountW       = 32;
	localparam int WayW         = 4;

	// Prefetch mode codes
	localparam logic [1:0] PF_NONE   = 2'd0;
	localparam logic [1:0] PF_ALWAYS = 2'd1;
	localparam logic [1:0] PF_MISS   = 2'd2;

	// Register indexes
	localparam int REG_PF_MODE   = 0;
	localparam int REG_WR_ALLOC  = 1;

	typedef struct packed {
		logic [1:0] pf_mode;
		logic       wr_alloc;
	} salct_cfg_t;
endpackage

### src/salct_cfg.sv
// APB configuration registers for the tag block.
module salct_cfg
	import salct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output salct_cfg_t  cfg
);
	logic [1:0] pf_mode_q;
	logic       wr_alloc_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_mode_q  <= PF_NONE;
			wr_alloc_q <= 1'b1;
		end else if (wr_en) begin
			if (paddr == 3'(4 * REG_PF_MODE)) pf_mode_q <= pwdata[1:0];
			if (paddr == 3'(4 * REG_WR_ALLOC)) wr_alloc_q <= pwdata[0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (paddr == 3'(4 * REG_PF_MODE)) prdata[1:0] = pf_mode_q;
		else if (paddr == 3'(4 * REG_WR_ALLOC)) prdata[0] = wr_alloc_q;
	end

	assign cfg.pf_mode  = pf_mode_q;
	assign cfg.wr_alloc = wr_alloc_q;
endmodule

### src/salct_mem.sv
// Set memory: tags, valid bits and LRU order of every set, one row per set.
module salct_mem #(
	parameter int ROW_W = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [ROW_W-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [ROW_W-1:0]         rdata
);
	logic [ROW_W-1:0] mem [DEPTH];

	// One write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### src/set_assoc_lru_cache_tags.sv
// Top level: set-associative LRU tag lookup with next-line prefetch.
// Usage:
//   Slave channel s_axis_* carries one request: tdata = {is_store, address}.
//   Master channel m_axis_* returns one result per request:
//   tdata = {hit_count, way, hit} (hit in bit 0).
//   APB port writes prefetch_mode (addr 0) and write_allocate (addr 4).
// Sequence:
//   A demand request passes from acceptance through read set, update and
//   result; a prefetch adds a read and an update of the next set before
//   the result. No new request is taken until the last one has left the
//   result state; the steps share the single port pair of the set memory.
// Reset:
//   A clearing pass writes every set row, one per cycle; s_axis_tready
//   stays low during it. Config writes are taken.
// Stall:
//   The result sits in an output register; a new request is accepted while
//   it waits, and its own result waits until the register is free.
module set_assoc_lru_cache_tags
	import salct_pkg::*;
#(
	parameter int WAYS       = DefWays,
	parameter int LINES      = DefLines,
	parameter int LINE_BYTES = DefLineBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // address[31:0], is_store[32], zeros
	input  logic        m_axis_tready,
	output logic        m_axis_tvalid,
	output logic [39:0] m_axis_tdata,  // hit[0], way[4:1], hit_count[36:5], zeros
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int NSETS  = LINES / WAYS;
	localparam int SETW   = (NSETS > 1) ? $clog2(NSETS) : 1;
	localparam int OFFW   = $clog2(LINE_BYTES);
	localparam int TAGW   = AddrW - OFFW - $clog2(NSETS);
	localparam int WIDXW  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W  = WAYS * (TAGW + 1 + WIDXW);

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_RD, ST_UPD, ST_PRD, ST_PUPD, ST_OUT}
		state_t;

	salct_cfg_t cfg;
	state_t     state_q;
	logic [AddrW-1:0] addr_q;
	logic       store_q;
	logic       hit_q;
	logic [WayW-1:0] way_q;
	logic [CountW-1:0] count_q;
	logic [SETW-1:0] clr_q;
	logic       ovalid_q;
	logic [36:0] odata_q;

	logic            we;
	logic [SETW-1:0] waddr, raddr;
	logic [ROW_W-1:0] wdata, rdata;

	logic [TAGW-1:0]  tag_v [WAYS];
	logic             vld_v [WAYS];
	logic [WIDXW-1:0] lru_v [WAYS];
	logic [ROW_W-1:0] init_row, upd_row;
	logic [AddrW-1:0] cur_addr;
	logic [TAGW-1:0]  cur_tag;
	logic             f_hit;
	logic [WIDXW-1:0] f_way, tgt_way, victim;
	logic             do_alloc, demand, pf_go;

	salct_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	salct_mem #(.ROW_W(ROW_W), .DEPTH(NSETS)) u_mem (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	// Unpack the row just read
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			tag_v[w] = rdata[w*(TAGW+1+WIDXW) +: TAGW];
			vld_v[w] = rdata[w*(TAGW+1+WIDXW) + TAGW];
			lru_v[w] = rdata[w*(TAGW+1+WIDXW) + TAGW + 1 +: WIDXW];
		end
	end

	// Reset row: invalid, position j holds way j
	always_comb begin
		init_row = '0;
		for (int w = 0; w < WAYS; w++)
			init_row[w*(TAGW+1+WIDXW) + TAGW + 1 +: WIDXW] = WIDXW'(w);
	end

	assign demand   = (state_q == ST_UPD);
	assign cur_addr = demand ? addr_q : addr_q + AddrW'(LINE_BYTES);
	assign cur_tag  = cur_addr[AddrW-1 -: TAGW];
	assign victim   = lru_v[WAYS-1];

	// Tag compare
	always_comb begin
		f_hit = 1'b0;
		f_way = '0;
		for (int w = WAYS - 1; w >= 0; w--)
			if (vld_v[w] && tag_v[w] == cur_tag) begin
				f_hit = 1'b1;
				f_way = WIDXW'(w);
			end
	end

	assign do_alloc = f_hit || !demand || !store_q || cfg.wr_alloc;
	assign tgt_way  = f_hit ? f_way : victim;

	// Move target to the front of the order, fill tag on miss
	always_comb begin
		logic seen;
		seen    = 1'b0;
		upd_row = rdata;
		for (int p = WAYS - 1; p >= 0; p--) begin
			if (p > 0) begin
				seen = 1'b0;
				for (int q = 0; q < p; q++) if (lru_v[q] == tgt_way) seen = 1'b1;
				if (!seen)
					upd_row[p*(TAGW+1+WIDXW) + TAGW + 1 +: WIDXW] = lru_v[p-1];
			end
		end
		upd_row[TAGW + 1 +: WIDXW] = tgt_way;
		if (!f_hit) begin
			for (int w = 0; w < WAYS; w++)
				if (WIDXW'(w) == victim) begin
					upd_row[w*(TAGW+1+WIDXW) +: TAGW] = cur_tag;
					upd_row[w*(TAGW+1+WIDXW) + TAGW] = 1'b1;
				end
		end
	end

	assign pf_go = (cfg.pf_mode == PF_ALWAYS) || (cfg.pf_mode == PF_MISS && !f_hit);

	// Memory ports
	always_comb begin
		we    = 1'b0;
		waddr = cur_addr[OFFW +: SETW];
		wdata = upd_row;
		raddr = addr_q[OFFW +: SETW];
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = init_row;
		end else if (state_q == ST_UPD || state_q == ST_PUPD) begin
			we = do_alloc;
		end
		if (state_q == ST_UPD || state_q == ST_PRD)
			raddr = SETW'((addr_q + AddrW'(LINE_BYTES)) >> OFFW);
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {3'b000, odata_q};

	// Sequencer: clear, read, update, optional prefetch, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			count_q  <= '0;
			ovalid_q <= 1'b0;
			addr_q   <= '0;
			store_q  <= 1'b0;
			hit_q    <= 1'b0;
			way_q    <= '0;
			odata_q  <= '0;
		end else begin
			// Hold the result flag until the receiver takes it
			if (state_q == ST_OUT && (!ovalid_q || m_axis_tready)) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SETW'(NSETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						addr_q  <= s_axis_tdata[31:0];
						store_q <= s_axis_tdata[32];
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_UPD;
				ST_UPD: begin
					hit_q <= f_hit;
					way_q <= do_alloc ? WayW'(tgt_way) : '0;
					if (f_hit) count_q <= count_q + 1'b1;
					state_q <= pf_go ? ST_PRD : ST_OUT;
				end
				ST_PRD: state_q <= ST_PUPD;
				ST_PUPD: state_q <= ST_OUT;
				ST_OUT: begin
					if (!ovalid_q || m_axis_tready) begin
						odata_q  <= {count_q, way_q, hit_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### tb/sv/tb_top.sv
// Testbench for the set-associative LRU tag block: random and directed requests, checked result by result.
module tb_top
	import salct_pkg::*;
();

	localparam int NumSets  = DefLines / DefWays;
	localparam int WdogMax  = 20000;

	// Tracks the tag state and the expected results of the tag block
	class lru_tag_scoreboard;
		logic [19:0] tags [DefLines];
		bit          valid [DefLines];
		logic [1:0]  order [DefLines];
		logic [31:0] hits;
		logic [1:0]  pf_mode;
		bit          wr_alloc;
		logic [36:0] pending [$];
		int          errors;
		int          checked;

		function void clear();
			for (int i = 0; i < DefLines; i++) begin
				tags[i]  = '0;
				valid[i] = 0;
				order[i] = 2'(i % DefWays);
			end
			hits     = '0;
			pf_mode  = PF_NONE;
			wr_alloc = 1;
		endfunction

		function bit lookup(int set, logic [19:0] tag, output int way);
			way = 0;
			for (int w = 0; w < DefWays; w++)
				if (valid[set*DefWays+w] && tags[set*DefWays+w] == tag) begin
					way = w;
					return 1;
				end
			return 0;
		endfunction

		function void promote(int set, int way);
			int pos;
			int b;
			b = set * DefWays;
			pos = DefWays - 1;
			for (int p = DefWays - 1; p >= 0; p--)
				if (order[b+p] == way) pos = p;
			for (int p = pos; p > 0; p--) order[b+p] = order[b+p-1];
			order[b] = 2'(way);
		endfunction

		function int fill(int set, logic [19:0] tag);
			int v;
			v = order[set*DefWays+DefWays-1];
			promote(set, v);
			tags[set*DefWays+v]  = tag;
			valid[set*DefWays+v] = 1;
			return v;
		endfunction

		// Note an accepted request and queue its expected result
		function void note_request(logic [31:0] addr, bit store);
			int way;
			int nway;
			bit hit;
			logic [31:0] nxt;
			way = 0;
			hit = lookup(addr[11:5], addr[31:12], way);
			if (hit) begin
				promote(addr[11:5], way);
				hits++;
			end else if (!store || wr_alloc)
				way = fill(addr[11:5], addr[31:12]);
			else
				way = 0;
			if (pf_mode == PF_ALWAYS || (pf_mode == PF_MISS && !hit)) begin
				nxt = addr + DefLineBytes;
				if (lookup(nxt[11:5], nxt[31:12], nway)) promote(nxt[11:5], nway);
				else void'(fill(nxt[11:5], nxt[31:12]));
			end
			pending.insert(pending.size(), {hits, way[3:0], hit});
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		// Compare an accepted result with the oldest expectation
		task check_result(logic [39:0] data);
			logic [36:0] e;
			checked++;
			if (pending.size() == 0) begin
				report("unexpected result", data[31:0], '0);
				return;
			end
			e = pending.pop_front();
			if (data[0] !== e[0]) report("hit", 32'(data[0]), 32'(e[0]));
			if (data[4:1] !== e[4:1]) report("way", 32'(data[4:1]), 32'(e[4:1]));
			if (data[36:5] !== e[36:5]) report("hit_count", data[36:5], e[36:5]);
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // address[31:0], is_store[32], zeros
	logic        m_axis_tready = 0;
	logic        m_axis_tvalid;
	logic [39:0] m_axis_tdata;       // hit[0], way[4:1], hit_count[36:5], zeros
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	lru_tag_scoreboard sb = new();
	bit   calm = 0;        // no idling in the last part
	int   hold_off = 0;    // long receiver stall request
	int   wdog = 0;
	int   n_stores = 0;

	set_assoc_lru_cache_tags uut (.*);

	always #4 clk = ~clk;

	// Receiver: random stalls, one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_axis_tready <= 0;
				repeat (hold_off) @(negedge clk);
				hold_off = 0;
			end
			if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 13);
				m_axis_tready <= 0;
				repeat (gap - 1) @(negedge clk);
			end else
				m_axis_tready <= 1;
		end
	end

	// Check results and feed the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				wdog <= 0;
			else
				wdog <= wdog + 1;
			if (wdog >= WdogMax) begin
				$display("watchdog expired");
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task cfg_write(int idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'(idx * 4); pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_PF_MODE) sb.pf_mode = val[1:0];
		else if (idx == REG_WR_ALLOC) sb.wr_alloc = val[0];
	endtask

	// Send one request and wait for its handshake
	task send(logic [31:0] addr, bit store);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 13);
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= {7'b0, store, addr};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(addr, store);
		n_stores += store;
		@(negedge clk);
	endtask

	task drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Mostly small address windows so sets fill and evict
	function logic [31:0] pick_addr();
		logic [31:0] a;
		a = $urandom();
		case ($urandom_range(0, 3))
			0: a = {20'($urandom_range(0, 5)), 7'($urandom_range(0, 3)), a[4:0]};
			1: a = {a[31:12] & 20'h7, a[11:0] & 12'h3ff};
			2: a = {a[31:12], 7'h7f, a[4:0]};
			default: ;
		endcase
		return a;
	endfunction

	initial begin
		sb.clear();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes, hits, misses, store miss without allocation, top wrap
		send(32'h0000_0000, 0);
		send(32'h0000_0000, 0);
		send(32'hFFFF_FFFF, 1);
		send(32'hFFFF_FFE0, 0);
		for (int i = 0; i < 5; i++) send(i << 14, 0);
		send(32'h0000_0000, 1);
		drain();
		cfg_write(REG_WR_ALLOC, 0);
		send(32'h1234_5660, 1);
		send(32'h1234_5660, 0);
		send(32'h1234_5660, 1);
		drain();
		cfg_write(REG_PF_MODE, 32'(PF_ALWAYS));
		send(32'hFFFF_FFF0, 0);
		send(32'h0000_0004, 0);
		send(32'h0000_4000, 1);
		drain();
		cfg_write(REG_PF_MODE, 32'(PF_MISS));
		send(32'hABCD_0000, 1);
		send(32'hABCD_0020, 0);
		send(32'hABCD_0000, 0);
		drain();
		cfg_write(REG_PF_MODE, 3);
		cfg_write(REG_WR_ALLOC, 32'hFFFF_FFFE);
		send(32'h5555_5555, 0);
		send(32'hAAAA_AAAA, 1);
		drain();

		// Random phases over every setting
		for (int ph = 0; ph < 8; ph++) begin
			cfg_write(REG_PF_MODE, ph % 4);
			cfg_write(REG_WR_ALLOC, ph / 4);
			if (ph == 3) hold_off = 400;
			for (int i = 0; i < 185; i++) begin
				if (ph == 7 && i == 100) calm = 1;
				send(pick_addr(), 1'($urandom_range(0, 1)));
			end
			drain();
		end

		$display("covered %0d results, %0d stores, all prefetch and allocate settings",
			sb.checked, n_stores);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
